>>> hdl/dcc_pkg.sv
// shared types, constants and lookup tables of the day-count / calendar converter
`default_nettype none

package dcc_pkg;

	// pipeline depth and per-stage load enables
	localparam int STAGES = 5;

	typedef struct packed {
		logic [STAGES:1] en;
	} pipe_ctl_t;

	// range limits
	localparam logic [15:0] DAY_MAX     = 16'd54786;
	localparam logic [16:0] SEC_MAX     = 17'd86399;
	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	localparam logic [11:0] YEAR_LO     = 12'd1950;
	localparam logic [11:0] YEAR_HI     = 12'd2099;
	localparam logic [3:0]  MONTH_HI    = 4'd12;
	localparam logic [4:0]  HOUR_HI     = 5'd23;
	localparam logic [5:0]  MIN_HI      = 6'd59;

	// day count to calendar constants
	localparam logic [16:0] DATE_OFS_A  = 17'd18204;
	localparam logic [17:0] DATE_OFS_B  = 18'd18234;
	localparam logic [11:0] GREG_NUM    = 12'd4000;
	localparam logic [20:0] GREG_DEN    = 21'd1461001;
	// floor(4000 * 2^32 / 1461001), low by at most one after the shift
	localparam logic [23:0] L_RECIP     = 24'd11758971;
	localparam logic [10:0] QUAD_DAYS   = 11'd1461;
	// ceil(80 * 2^20 / 2447), exact for the reachable day-of-year span
	localparam logic [15:0] M_RECIP     = 16'd34282;
	localparam logic [3:0]  JAN_INDEX   = 4'd11;
	localparam logic [11:0] BASE_YEAR   = 12'd1900;
	localparam logic [11:0] YEAR_MOD    = 12'd1900;
	localparam logic [11:0] YEAR_MOD2   = 12'd3800;

	// time of day constants
	localparam logic [5:0]  SIXTY       = 6'd60;
	// ceil(2^23 / 60) and ceil(2^17 / 60)
	localparam logic [17:0] DIV60_R23   = 18'd139811;
	localparam logic [11:0] DIV60_R17   = 12'd2185;

	// floor(2447 * m / 80): days before month index m, counted from march
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd30;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd91;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd152;
			4'd6:    r = 9'd183;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd244;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd305;
			4'd11:   r = 9'd336;
			4'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// floor(367 * (mo - 2 + 12 * jj) / 12) for every raw month code
	function automatic logic [8:0] month_term(input logic [3:0] mo);
		logic [8:0] r;
		case (mo)
			4'd0:    r = 9'd305;
			4'd1:    r = 9'd336;
			4'd2:    r = 9'd367;
			4'd3:    r = 9'd30;
			4'd4:    r = 9'd61;
			4'd5:    r = 9'd91;
			4'd6:    r = 9'd122;
			4'd7:    r = 9'd152;
			4'd8:    r = 9'd183;
			4'd9:    r = 9'd214;
			4'd10:   r = 9'd244;
			4'd11:   r = 9'd275;
			4'd12:   r = 9'd305;
			4'd13:   r = 9'd336;
			4'd14:   r = 9'd367;
			default: r = 9'd30;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/dcc_date_path.sv
// day count to calendar date pipeline (year, month, day)
`default_nettype none

module dcc_date_path (
	input  logic              clk,
	input  dcc_pkg::pipe_ctl_t ctl,
	input  logic [15:0]       day_count,
	output logic [11:0]       cal_year,
	output logic [3:0]        cal_month,
	output logic [4:0]        cal_day
);
	import dcc_pkg::*;

	logic [16:0] t_in;
	logic [40:0] l_prod;
	logic [29:0] lhs, rhs;
	logic [8:0]  l_inc;
	logic [18:0] yr_prod;
	logic [17:0] n_full;
	logic [24:0] m_prod;
	logic [8:0]  day_full;
	logic        jj;

	logic [15:0] d_s1, d_s2;
	logic [16:0] t_s1;
	logic [8:0]  lest_s1;
	logic [7:0]  l_s2, l_s3, l_s4;
	logic [8:0]  n_s3, n_s4;
	logic [3:0]  m_s4;
	logic [11:0] year_s5;
	logic [3:0]  month_s5;
	logic [4:0]  day_s5;

	// stage 1: year estimate by reciprocal multiply
	assign t_in   = 17'(day_count) + DATE_OFS_A;
	assign l_prod = 41'(t_in) * 41'(L_RECIP);

	// stage 2: correct the estimate by one where the remainder allows it
	assign lhs   = 30'(t_s1) * 30'(GREG_NUM);
	assign l_inc = lest_s1 + 9'd1;
	assign rhs   = 30'(l_inc) * 30'(GREG_DEN);

	// stage 3: day within the march-based year
	assign yr_prod = 19'(l_s2) * 19'(QUAD_DAYS);
	assign n_full  = 18'(d_s2) + DATE_OFS_B - 18'(yr_prod[18:2]);

	// stage 4: month index by reciprocal multiply
	assign m_prod = 25'(n_s3) * 25'(M_RECIP);

	// stage 5: day, month and year fields
	assign day_full = n_s4 - month_start(m_s4);
	assign jj       = (m_s4 >= JAN_INDEX);

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			d_s1    <= day_count;
			t_s1    <= t_in;
			lest_s1 <= l_prod[40:32];
		end
		if (ctl.en[2]) begin
			d_s2 <= d_s1;
			l_s2 <= (lhs >= rhs) ? l_inc[7:0] : lest_s1[7:0];
		end
		if (ctl.en[3]) begin
			l_s3 <= l_s2;
			n_s3 <= n_full[8:0];
		end
		if (ctl.en[4]) begin
			l_s4 <= l_s3;
			n_s4 <= n_s3;
			m_s4 <= m_prod[23:20];
		end
		if (ctl.en[5]) begin
			day_s5   <= day_full[4:0];
			month_s5 <= jj ? (m_s4 - 4'd10) : (m_s4 + 4'd2);
			year_s5  <= BASE_YEAR + 12'(l_s4) + 12'(jj);
		end
	end

	assign cal_year  = year_s5;
	assign cal_month = month_s5;
	assign cal_day   = day_s5;

endmodule

`default_nettype wire

>>> hdl/dcc_time_path.sv
// seconds of day to hour, minute and second pipeline
`default_nettype none

module dcc_time_path (
	input  logic              clk,
	input  dcc_pkg::pipe_ctl_t ctl,
	input  logic [16:0]       seconds_in_day,
	output logic [4:0]        cal_hour,
	output logic [5:0]        cal_minute,
	output logic [5:0]        cal_second
);
	import dcc_pkg::*;

	logic [34:0] q_prod;
	logic [23:0] h_prod;
	logic [16:0] sec_full;
	logic [11:0] min_full;

	logic [16:0] s_s1;
	logic [11:0] q60_s1, q60_s2;
	logic [5:0]  hr_s2, hr_s3, hr_s4, hr_s5;
	logic [5:0]  sec_s2, sec_s3, sec_s4, sec_s5;
	logic [5:0]  min_s3, min_s4, min_s5;

	// stage 1: whole minutes
	assign q_prod = 35'(seconds_in_day) * 35'(DIV60_R23);

	// stage 2: whole hours and leftover seconds
	assign h_prod   = 24'(q60_s1) * 24'(DIV60_R17);
	assign sec_full = s_s1 - 17'(q60_s1) * 17'(SIXTY);

	// stage 3: leftover minutes
	assign min_full = q60_s2 - 12'(hr_s2) * 12'(SIXTY);

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			s_s1   <= seconds_in_day;
			q60_s1 <= q_prod[34:23];
		end
		if (ctl.en[2]) begin
			q60_s2 <= q60_s1;
			hr_s2  <= h_prod[22:17];
			sec_s2 <= sec_full[5:0];
		end
		if (ctl.en[3]) begin
			hr_s3  <= hr_s2;
			sec_s3 <= sec_s2;
			min_s3 <= min_full[5:0];
		end
		if (ctl.en[4]) begin
			hr_s4  <= hr_s3;
			sec_s4 <= sec_s3;
			min_s4 <= min_s3;
		end
		if (ctl.en[5]) begin
			hr_s5  <= hr_s4;
			sec_s5 <= sec_s4;
			min_s5 <= min_s4;
		end
	end

	assign cal_hour   = hr_s5[4:0];
	assign cal_minute = min_s5;
	assign cal_second = sec_s5;

endmodule

`default_nettype wire

>>> hdl/dcc_count_path.sv
// calendar date and time to day count pipeline, with clamping
`default_nettype none

module dcc_count_path (
	input  logic              clk,
	input  dcc_pkg::pipe_ctl_t ctl,
	input  logic [11:0]       year,
	input  logic [3:0]        month,
	input  logic [4:0]        day_of_month,
	input  logic [4:0]        hour,
	input  logic [5:0]        minute,
	input  logic [5:0]        second,
	output logic [15:0]       result_days,
	output logic [16:0]       result_seconds,
	output logic              clamped
);
	import dcc_pkg::*;

	logic [10:0]        ym;
	logic signed [1:0]  jj;
	logic [10:0]        tm;
	logic [9:0]         dsum;
	logic signed [22:0] yr_prod;
	logic               wrap;
	logic signed [20:0] days;

	logic [10:0]        ym_s1;
	logic signed [1:0]  jj_s1;
	logic [8:0]         mt_s1;
	logic [4:0]         dm_s1;
	logic [10:0]        tm_s1;
	logic [5:0]         se_s1;
	logic signed [11:0] l_s2;
	logic [16:0]        tsec_s2, tsec_s3, tsec_s4, tsec_s5;
	logic signed [15:0] base_s2, base_s3;
	logic signed [20:0] yt_s3;
	logic               wrap_s3;
	logic signed [20:0] days_s4;
	logic [15:0]        days_s5;
	logic               clamp_s5;

	// stage 1: year modulo 1900, january/february shift, month term
	always_comb begin
		if (year >= YEAR_MOD2) begin
			ym = 11'(year - YEAR_MOD2);
		end else if (year >= YEAR_MOD) begin
			ym = 11'(year - YEAR_MOD);
		end else begin
			ym = year[10:0];
		end
		if (month <= 4'd2) begin
			jj = 2'sd1;
		end else if (month == 4'd15) begin
			jj = -2'sd1;
		end else begin
			jj = 2'sd0;
		end
	end
	assign tm = 11'(hour) * 11'(SIXTY) + 11'(minute);

	// stage 2: shifted year, day base, seconds of day
	assign dsum = 10'(dm_s1) + 10'(mt_s1);

	// stage 3: whole-year days and day carry from the time of day
	assign yr_prod = 23'(l_s2) * $signed(23'(QUAD_DAYS));
	assign wrap    = (tsec_s2 >= SEC_PER_DAY);

	// stage 4: total day count
	assign days = yt_s3 + 21'(base_s3) + $signed({20'd0, wrap_s3});

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			ym_s1 <= ym;
			jj_s1 <= jj;
			mt_s1 <= month_term(month);
			dm_s1 <= day_of_month;
			tm_s1 <= tm;
			se_s1 <= second;
		end
		if (ctl.en[2]) begin
			l_s2    <= $signed({1'b0, ym_s1}) - 12'(jj_s1);
			tsec_s2 <= 17'(tm_s1) * 17'(SIXTY) + 17'(se_s1);
			base_s2 <= $signed({6'd0, dsum}) - $signed(16'(DATE_OFS_B));
		end
		if (ctl.en[3]) begin
			yt_s3   <= yr_prod[22:2];
			base_s3 <= base_s2;
			wrap_s3 <= wrap;
			tsec_s3 <= wrap ? (tsec_s2 - SEC_PER_DAY) : tsec_s2;
		end
		if (ctl.en[4]) begin
			days_s4 <= days;
			tsec_s4 <= tsec_s3;
		end
		if (ctl.en[5]) begin
			tsec_s5 <= tsec_s4;
			if (days_s4 < 21'sd0) begin
				days_s5  <= 16'd0;
				clamp_s5 <= 1'b1;
			end else if (days_s4 > $signed(21'(DAY_MAX))) begin
				days_s5  <= DAY_MAX;
				clamp_s5 <= 1'b1;
			end else begin
				days_s5  <= days_s4[15:0];
				clamp_s5 <= 1'b0;
			end
		end
	end

	assign result_days    = days_s5;
	assign result_seconds = tsec_s5;
	assign clamped        = clamp_s5;

endmodule

`default_nettype wire

>>> hdl/mjd1950_calendar_converter_unit.sv
// top level of the day-count / calendar converter: handshake, range checks, result packing
//
// Converts between a day count since 1 Jan 1950 (plus seconds of day) and calendar
// fields, in either direction, one conversion per transaction.
// Input channel s_axis_*: tuser selects the direction (0 = count to calendar,
// 1 = calendar to count), tdata carries both sets of input fields.
// Output channel m_axis_*: tdata carries the count and calendar fields, the ones
// not used by the selected direction read as zero; tuser is the range error flag.
// A result is offered once its item has passed through every stage register; a new item
// can enter on every cycle unless all stages are full and the output stalls, so sustained
// throughput is one conversion per cycle while the output accepts results.
// The five stages are cut at the multiplies of the year estimate, its correction,
// the whole-year days and the month estimate, with field lookups and clamping last.
// Each stage loads when it is empty or the stage after it moves, so a stalled
// output fills the pipeline bubbles first; s_axis_tready drops only when all five
// stages hold items. No item is lost or repeated across a stall.
// Reset clears all stage valid flags; data registers are not reset.
`default_nettype none

module mjd1950_calendar_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// day_count, seconds_in_day, year, month, day_of_month, hour, minute, second, pad
	input  logic [71:0] s_axis_tdata,
	// mode
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result_days, result_seconds, cal_year, cal_month, cal_day, cal_hour,
	// cal_minute, cal_second, pad
	output logic [71:0] m_axis_tdata,
	// range_error
	output logic        m_axis_tuser
);
	import dcc_pkg::*;

	pipe_ctl_t ctl;

	logic [15:0] in_day_count;
	logic [16:0] in_seconds;
	logic [11:0] in_year;
	logic [3:0]  in_month;
	logic [4:0]  in_dom;
	logic [4:0]  in_hour;
	logic [5:0]  in_minute;
	logic [5:0]  in_second;
	logic        err_in;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        mode_s1, mode_s2, mode_s3, mode_s4, mode_s5;
	logic        err_s1, err_s2, err_s3, err_s4, err_s5;

	logic [11:0] cal_year;
	logic [3:0]  cal_month;
	logic [4:0]  cal_day;
	logic [4:0]  cal_hour;
	logic [5:0]  cal_minute;
	logic [5:0]  cal_second;
	logic [15:0] result_days;
	logic [16:0] result_seconds;
	logic        clamped;

	// input field unpacking
	assign in_day_count = s_axis_tdata[15:0];
	assign in_seconds   = s_axis_tdata[32:16];
	assign in_year      = s_axis_tdata[44:33];
	assign in_month     = s_axis_tdata[48:45];
	assign in_dom       = s_axis_tdata[53:49];
	assign in_hour      = s_axis_tdata[58:54];
	assign in_minute    = s_axis_tdata[64:59];
	assign in_second    = s_axis_tdata[70:65];

	// input range check for the selected direction
	always_comb begin
		if (s_axis_tuser) begin
			err_in = (in_year < YEAR_LO) || (in_year > YEAR_HI) || (in_month == 4'd0) ||
				(in_month > MONTH_HI) || (in_dom == 5'd0) || (in_hour > HOUR_HI) ||
				(in_minute > MIN_HI) || (in_second > MIN_HI);
		end else begin
			err_in = (in_day_count > DAY_MAX) || (in_seconds > SEC_MAX);
		end
	end

	// per-stage load enables, a stage moves when empty or when its successor moves
	always_comb begin
		ctl.en[5] = !v_s5 || m_axis_tready;
		ctl.en[4] = !v_s4 || ctl.en[5];
		ctl.en[3] = !v_s3 || ctl.en[4];
		ctl.en[2] = !v_s2 || ctl.en[3];
		ctl.en[1] = !v_s1 || ctl.en[2];
	end

	assign s_axis_tready = ctl.en[1];

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ctl.en[1]) v_s1 <= s_axis_tvalid;
			if (ctl.en[2]) v_s2 <= v_s1;
			if (ctl.en[3]) v_s3 <= v_s2;
			if (ctl.en[4]) v_s4 <= v_s3;
			if (ctl.en[5]) v_s5 <= v_s4;
		end
	end

	// mode and input error travel with the item
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			mode_s1 <= s_axis_tuser;
			err_s1  <= err_in;
		end
		if (ctl.en[2]) begin
			mode_s2 <= mode_s1;
			err_s2  <= err_s1;
		end
		if (ctl.en[3]) begin
			mode_s3 <= mode_s2;
			err_s3  <= err_s2;
		end
		if (ctl.en[4]) begin
			mode_s4 <= mode_s3;
			err_s4  <= err_s3;
		end
		if (ctl.en[5]) begin
			mode_s5 <= mode_s4;
			err_s5  <= err_s4;
		end
	end

	dcc_date_path u_date (
		.clk       (clk),
		.ctl       (ctl),
		.day_count (in_day_count),
		.cal_year  (cal_year),
		.cal_month (cal_month),
		.cal_day   (cal_day)
	);

	dcc_time_path u_time (
		.clk            (clk),
		.ctl            (ctl),
		.seconds_in_day (in_seconds),
		.cal_hour       (cal_hour),
		.cal_minute     (cal_minute),
		.cal_second     (cal_second)
	);

	dcc_count_path u_count (
		.clk            (clk),
		.ctl            (ctl),
		.year           (in_year),
		.month          (in_month),
		.day_of_month   (in_dom),
		.hour           (in_hour),
		.minute         (in_minute),
		.second         (in_second),
		.result_days    (result_days),
		.result_seconds (result_seconds),
		.clamped        (clamped)
	);

	// result packing, unused direction reads as zero
	always_comb begin
		m_axis_tdata = '0;
		if (mode_s5) begin
			m_axis_tdata[15:0]  = result_days;
			m_axis_tdata[32:16] = result_seconds;
		end else begin
			m_axis_tdata[44:33] = cal_year;
			m_axis_tdata[48:45] = cal_month;
			m_axis_tdata[53:49] = cal_day;
			m_axis_tdata[58:54] = cal_hour;
			m_axis_tdata[64:59] = cal_minute;
			m_axis_tdata[70:65] = cal_second;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tuser  = err_s5 || (mode_s5 && clamped);

`ifndef ASSERT_OFF
	// input side only backs up when the output holds a result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result pending");

	// clamped day count never exceeds the upper limit
	a_days_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && mode_s5 |-> m_axis_tdata[15:0] <= DAY_MAX)
		else $error("result day count above limit");

	// reciprocal month estimate lands on a real month for any day count
	a_month_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !mode_s5 |->
		m_axis_tdata[48:45] >= 4'd1 && m_axis_tdata[48:45] <= MONTH_HI)
		else $error("calendar month out of range");
`endif

endmodule

`default_nettype wire

>>> tb/mjd1950_calendar_converter_unit_tb.sv
// self-checking testbench of the day-count / calendar converter with its own conversion predictor
`default_nettype none

module mjd1950_calendar_converter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// direction codes carried in s_axis_tuser
	localparam logic MODE_TO_CAL   = 1'b0;
	localparam logic MODE_TO_COUNT = 1'b1;

	// valid span and calendar constants
	localparam longint DAY_LIMIT   = 54786;
	localparam longint SECS_IN_DAY = 86400;
	localparam longint FIRST_YEAR  = 1950;
	localparam longint LAST_YEAR   = 2099;

	// run control
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int HOLD_CYCLES    = 80;

	// input fields, first field in the lowest bits
	typedef struct packed {
		logic        pad;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day_of_month;
		logic [3:0]  month;
		logic [11:0] year;
		logic [16:0] seconds_in_day;
		logic [15:0] day_count;
	} date_in_t;

	// result fields, first field in the lowest bits
	typedef struct packed {
		logic        pad;
		logic [5:0]  cal_second;
		logic [5:0]  cal_minute;
		logic [4:0]  cal_hour;
		logic [4:0]  cal_day;
		logic [3:0]  cal_month;
		logic [11:0] cal_year;
		logic [16:0] result_seconds;
		logic [15:0] result_days;
	} date_out_t;

	typedef struct {
		date_out_t fields;
		logic      range_error;
	} conversion_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic        m_axis_tuser;

	conversion_t expected_conversions[$];
	int          mismatches = 0;
	int          stall_cycles = 0;
	bit          src_idle_en = 1'b0;
	bit          sink_idle_en = 1'b0;
	bit          hold_req = 1'b0;
	bit          holding = 1'b0;

	mjd1950_calendar_converter_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// floor division, divisor always positive
	function automatic longint floor_quot(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	// predicted result of one conversion
	function automatic conversion_t calc_conversion(input logic mode, input date_in_t f);
		conversion_t r;
		longint d, s, l, n, m, jj, y, mo, dm, days, tsec;
		r.fields = '0;
		if (mode == MODE_TO_CAL) begin
			d = f.day_count;
			s = f.seconds_in_day;
			r.range_error = (d > DAY_LIMIT) || (s > SECS_IN_DAY - 1);
			l = floor_quot(4000 * (d + 18204), 1461001);
			n = d - floor_quot(1461 * l, 4) + 18234;
			m = floor_quot(80 * n, 2447);
			jj = floor_quot(m, 11);
			r.fields.cal_day    = 5'(n - floor_quot(2447 * m, 80));
			r.fields.cal_month  = 4'(m + 2 - 12 * jj);
			r.fields.cal_year   = 12'(1900 + l + jj);
			r.fields.cal_hour   = 5'(s / 3600);
			r.fields.cal_minute = 6'((s / 60) % 60);
			r.fields.cal_second = 6'(s % 60);
		end else begin
			y  = f.year;
			mo = f.month;
			dm = f.day_of_month;
			r.range_error = (y < FIRST_YEAR) || (y > LAST_YEAR) || (mo < 1) || (mo > 12) ||
				(dm < 1) || (f.hour > 23) || (f.minute > 59) || (f.second > 59);
			jj = floor_quot(14 - mo, 12);
			l = y - 1900 * floor_quot(y, 1900) - jj;
			days = dm - 18234 + floor_quot(1461 * l, 4) +
				floor_quot(367 * (mo - 2 + 12 * jj), 12);
			tsec = (longint'(f.hour) * 60 + longint'(f.minute)) * 60 + longint'(f.second);
			// whole days in the time of day carry into the count
			days = days + tsec / SECS_IN_DAY;
			tsec = tsec % SECS_IN_DAY;
			if (days < 0) begin
				days = 0;
				r.range_error = 1'b1;
			end else if (days > DAY_LIMIT) begin
				days = DAY_LIMIT;
				r.range_error = 1'b1;
			end
			r.fields.result_days    = 16'(days);
			r.fields.result_seconds = 17'(tsec);
		end
		return r;
	endfunction

	// count-to-calendar item, calendar fields filled with noise
	function automatic date_in_t count_item(input longint d, input longint s);
		date_in_t f;
		f = date_in_t'({$urandom, $urandom, $urandom});
		f.pad = 1'b0;
		f.day_count = 16'(d);
		f.seconds_in_day = 17'(s);
		return f;
	endfunction

	// calendar-to-count item, count fields filled with noise
	function automatic date_in_t cal_item(input longint y, input longint mo, input longint dm,
		input longint h, input longint mi, input longint se);
		date_in_t f;
		f = date_in_t'({$urandom, $urandom, $urandom});
		f.pad = 1'b0;
		f.year = 12'(y);
		f.month = 4'(mo);
		f.day_of_month = 5'(dm);
		f.hour = 5'(h);
		f.minute = 6'(mi);
		f.second = 6'(se);
		return f;
	endfunction

	// well-formed item of either direction
	function automatic date_in_t valid_item(input logic mode);
		if (mode == MODE_TO_CAL) begin
			return count_item($urandom_range(0, DAY_LIMIT), $urandom_range(0, SECS_IN_DAY - 1));
		end
		return cal_item($urandom_range(FIRST_YEAR, LAST_YEAR), $urandom_range(1, 12),
			$urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59),
			$urandom_range(0, 59));
	endfunction

	// one input transaction, with an optional random gap in front
	task automatic send_conversion(input logic mode, input date_in_t f);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= f;
		s_axis_tuser <= mode;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	// field compare, first ten reported
	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch in %s: expected %0d, got %0d", name, want, got);
			end
		end
	endtask

	// predict every accepted input transaction
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_conversions.push_back(calc_conversion(s_axis_tuser, date_in_t'(s_axis_tdata)));
		end
	end

	// check every accepted output transaction against the oldest prediction
	always @(posedge clk) begin
		conversion_t want;
		date_out_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = date_out_t'(m_axis_tdata);
			if (expected_conversions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result transaction: tdata %h tuser %b",
						m_axis_tdata, m_axis_tuser);
				end
			end else begin
				want = expected_conversions.pop_front();
				check_field("result_days", want.fields.result_days, got.result_days);
				check_field("result_seconds", want.fields.result_seconds, got.result_seconds);
				check_field("cal_year", want.fields.cal_year, got.cal_year);
				check_field("cal_month", want.fields.cal_month, got.cal_month);
				check_field("cal_day", want.fields.cal_day, got.cal_day);
				check_field("cal_hour", want.fields.cal_hour, got.cal_hour);
				check_field("cal_minute", want.fields.cal_minute, got.cal_minute);
				check_field("cal_second", want.fields.cal_second, got.cal_second);
				check_field("range_error", want.range_error, m_axis_tuser);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", stall_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls, long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				holding = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				holding = 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// extremes, out-of-range counts and times
	task automatic test_count_to_calendar();
		send_conversion(MODE_TO_CAL, count_item(0, 0));
		send_conversion(MODE_TO_CAL, count_item(DAY_LIMIT, SECS_IN_DAY - 1));
		send_conversion(MODE_TO_CAL, count_item(DAY_LIMIT + 1, 0));
		send_conversion(MODE_TO_CAL, count_item(0, SECS_IN_DAY));
		send_conversion(MODE_TO_CAL, count_item(65535, 131071));
		// leap day of 2000 at noon
		send_conversion(MODE_TO_CAL, count_item(18321, 43200));
		send_conversion(MODE_TO_CAL, count_item(3652, 3599));
		send_conversion(MODE_TO_CAL, count_item(21914, 60));
	endtask

	// extremes, bad fields, carry of time overflow, clamping, impossible dates
	task automatic test_calendar_to_count();
		send_conversion(MODE_TO_COUNT, cal_item(1950, 1, 1, 0, 0, 0));
		send_conversion(MODE_TO_COUNT, cal_item(2099, 12, 31, 23, 59, 59));
		// count below zero, clamped
		send_conversion(MODE_TO_COUNT, cal_item(1950, 1, 0, 0, 0, 0));
		// time overflow pushes the count above the span
		send_conversion(MODE_TO_COUNT, cal_item(2099, 12, 31, 31, 63, 63));
		send_conversion(MODE_TO_COUNT, cal_item(2024, 6, 15, 24, 0, 0));
		send_conversion(MODE_TO_COUNT, cal_item(2000, 2, 29, 12, 0, 0));
		// 31 February rolls into March
		send_conversion(MODE_TO_COUNT, cal_item(2001, 2, 31, 0, 0, 0));
		send_conversion(MODE_TO_COUNT, cal_item(0, 0, 0, 0, 0, 0));
		send_conversion(MODE_TO_COUNT, cal_item(4095, 15, 31, 31, 63, 63));
		send_conversion(MODE_TO_COUNT, cal_item(1949, 13, 1, 0, 60, 0));
		send_conversion(MODE_TO_COUNT, cal_item(2100, 14, 1, 0, 0, 60));
	endtask

	// well-formed items of both directions with idling on both sides
	task automatic test_random_valid(input int count);
		logic mode;
		for (int i = 0; i < count; i++) begin
			mode = logic'($urandom_range(0, 1));
			send_conversion(mode, valid_item(mode));
		end
	endtask

	// raw values over the full field widths
	task automatic test_random_raw(input int count);
		date_in_t f;
		for (int i = 0; i < count; i++) begin
			f = date_in_t'({$urandom, $urandom, $urandom});
			f.pad = 1'b0;
			send_conversion(logic'($urandom_range(0, 1)), f);
		end
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure(input int count);
		logic mode;
		src_idle_en = 1'b0;
		hold_req = 1'b1;
		wait (holding);
		for (int i = 0; i < count; i++) begin
			mode = logic'($urandom_range(0, 1));
			send_conversion(mode, valid_item(mode));
		end
	endtask

	// back-to-back stream, no idling anywhere
	task automatic test_streaming(input int count);
		logic mode;
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		for (int i = 0; i < count; i++) begin
			mode = logic'($urandom_range(0, 1));
			send_conversion(mode, valid_item(mode));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		test_count_to_calendar();
		test_calendar_to_count();
		test_random_valid(500);
		test_random_raw(200);
		test_backpressure(40);
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		test_random_valid(50);
		test_streaming(150);
		s_axis_tvalid <= 1'b0;
		while (expected_conversions.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_conversions.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
hdl/dcc_pkg.sv
hdl/dcc_date_path.sv
hdl/dcc_time_path.sv
hdl/dcc_count_path.sv
hdl/mjd1950_calendar_converter_unit.sv
tb/mjd1950_calendar_converter_unit_tb.sv
